/* rtl/dclp_pkg.sv */
// ----------------------------------------------------------------------------
// dclp_pkg: shared types and constants of the drive command line parser
// Holds the byte classes, queue item layout, result codes and default sizes.
// ----------------------------------------------------------------------------
package dclp_pkg;

    // default sizes
    localparam int LINE_CAPACITY_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int SPEED_W  = 16;
    localparam int STATUS_W = 2;
    localparam int MAG_W    = 17;
    localparam int DIGIT_W  = 4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_UPPER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LOWER = 1'd1;

    // reset values of the limits
    localparam logic [SPEED_W-1:0] SPEED_UPPER_RESET = 16'sd100;
    localparam logic [SPEED_W-1:0] SPEED_LOWER_RESET = -16'sd100;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_DRIVE      = 2'd1,
        ST_STOP       = 2'd2,
        ST_ERROR      = 2'd3
    } status_t;

    // what the back end has to do with one item
    typedef enum logic [2:0] {
        KIND_SKIP     = 3'd0,  // byte with no parse effect, status incomplete
        KIND_CHAR     = 3'd1,  // byte to feed the parser
        KIND_END_STOP = 3'd2,  // line end after an exact stop word
        KIND_END_EVAL = 3'd3,  // line end, evaluate the drive command
        KIND_OVERFLOW = 3'd4   // line hit capacity and is dropped
    } item_kind_t;

    // character classes seen by the parser
    typedef enum logic [2:0] {
        CC_SPACE    = 3'd0,  // space or tab
        CC_WS_OTHER = 3'd1,  // vertical tab or form feed
        CC_DIGIT    = 3'd2,
        CC_PLUS     = 3'd3,
        CC_MINUS    = 3'd4,
        CC_COMMA    = 3'd5,
        CC_OTHER    = 3'd6
    } char_class_t;

    // one classified item between front and back
    typedef struct packed {
        item_kind_t          kind;
        char_class_t         cls;
        logic [DIGIT_W-1:0]  digit;
    } q_item_t;

endpackage

/* rtl/dclp_front.sv */
// ----------------------------------------------------------------------------
// dclp_front: byte intake and classification
// Tracks line length, NUL truncation and the stop word, and turns every
// received byte into one classified item for the back end.
// ----------------------------------------------------------------------------
module dclp_front #(
    parameter int LINE_CAPACITY = dclp_pkg::LINE_CAPACITY_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_valid,
    input  logic [dclp_pkg::BYTE_W-1:0] byte_data,
    output logic                        item_valid,
    output dclp_pkg::q_item_t           item
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(LINE_CAPACITY - 1);

    // stop word tracker states
    typedef enum logic [9:0] {
        SM_NONE = 10'b0000000001,
        SM_U1   = 10'b0000000010,
        SM_U2   = 10'b0000000100,
        SM_U3   = 10'b0000001000,
        SM_U4   = 10'b0000010000,
        SM_L1   = 10'b0000100000,
        SM_L2   = 10'b0001000000,
        SM_L3   = 10'b0010000000,
        SM_L4   = 10'b0100000000,
        SM_FAIL = 10'b1000000000
    } stop_state_t;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             trunc_reg, trunc_next;
    stop_state_t      sm_reg, sm_next, sm_step;
    logic             is_term;
    dclp_pkg::char_class_t cls;
    logic [7:0]       digit_off;

    assign is_term   = (byte_data == CH_LF) || (byte_data == CH_CR);
    assign digit_off = byte_data - CH_ZERO;

    // character class
    always_comb begin
        if (byte_data == CH_SPACE || byte_data == CH_TAB) begin
            cls = dclp_pkg::CC_SPACE;
        end else if (byte_data == CH_VT || byte_data == CH_FF) begin
            cls = dclp_pkg::CC_WS_OTHER;
        end else if (byte_data >= CH_ZERO && byte_data <= CH_NINE) begin
            cls = dclp_pkg::CC_DIGIT;
        end else if (byte_data == CH_PLUS) begin
            cls = dclp_pkg::CC_PLUS;
        end else if (byte_data == CH_MINUS) begin
            cls = dclp_pkg::CC_MINUS;
        end else if (byte_data == CH_COMMA) begin
            cls = dclp_pkg::CC_COMMA;
        end else begin
            cls = dclp_pkg::CC_OTHER;
        end
    end

    // stop word tracker step for a parsed byte
    always_comb begin
        unique case (sm_reg)
            SM_NONE: begin
                if (byte_data == "S")      sm_step = SM_U1;
                else if (byte_data == "s") sm_step = SM_L1;
                else                       sm_step = SM_FAIL;
            end
            SM_U1:   sm_step = (byte_data == "T") ? SM_U2 : SM_FAIL;
            SM_U2:   sm_step = (byte_data == "O") ? SM_U3 : SM_FAIL;
            SM_U3:   sm_step = (byte_data == "P") ? SM_U4 : SM_FAIL;
            SM_L1:   sm_step = (byte_data == "t") ? SM_L2 : SM_FAIL;
            SM_L2:   sm_step = (byte_data == "o") ? SM_L3 : SM_FAIL;
            SM_L3:   sm_step = (byte_data == "p") ? SM_L4 : SM_FAIL;
            default: sm_step = SM_FAIL;
        endcase
    end

    // line bookkeeping and item build
    always_comb begin
        len_next   = len_reg;
        trunc_next = trunc_reg;
        sm_next    = sm_reg;
        item.kind  = dclp_pkg::KIND_SKIP;
        item.cls   = cls;
        item.digit = digit_off[dclp_pkg::DIGIT_W-1:0];
        if (is_term) begin
            if (len_reg != '0) begin
                if (sm_reg == SM_U4 || sm_reg == SM_L4) begin
                    item.kind = dclp_pkg::KIND_END_STOP;
                end else begin
                    item.kind = dclp_pkg::KIND_END_EVAL;
                end
                len_next   = '0;
                trunc_next = 1'b0;
                sm_next    = SM_NONE;
            end
        end else if (len_reg != LAST_LEN) begin
            len_next = len_reg + 1'b1;
            if (byte_data == CH_NUL) begin
                trunc_next = 1'b1;
            end else if (!trunc_reg) begin
                sm_next   = sm_step;
                item.kind = dclp_pkg::KIND_CHAR;
            end
        end else begin
            item.kind  = dclp_pkg::KIND_OVERFLOW;
            len_next   = '0;
            trunc_next = 1'b0;
            sm_next    = SM_NONE;
        end
    end

    assign item_valid = byte_valid;

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            trunc_reg <= 1'b0;
            sm_reg    <= SM_NONE;
        end else if (byte_valid) begin
            len_reg   <= len_next;
            trunc_reg <= trunc_next;
            sm_reg    <= sm_next;
        end
    end

endmodule

/* rtl/dclp_queue.sv */
// ----------------------------------------------------------------------------
// dclp_queue: short item queue between front and back
// Small register FIFO so that intake and parsing stall independently.
// ----------------------------------------------------------------------------
module dclp_queue #(
    parameter int DEPTH = dclp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dclp_pkg::q_item_t push_item,
    output logic              in_ready,
    input  logic              pop,
    output logic              out_valid,
    output dclp_pkg::q_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    dclp_pkg::q_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/dclp_back.sv */
// ----------------------------------------------------------------------------
// dclp_back: parser and result stage
// Runs the integer,integer syntax machine on classified items, saturates and
// clamps the speeds at line end and holds one result for the output side.
// ----------------------------------------------------------------------------
module dclp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [dclp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dclp_pkg::SPEED_W-1:0]         cfg_data,
    input  logic                                 item_valid,
    input  dclp_pkg::q_item_t                    item,
    output logic                                 item_pop,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [dclp_pkg::STATUS_W-1:0]        res_status,
    output logic [dclp_pkg::SPEED_W-1:0]         res_left,
    output logic [dclp_pkg::SPEED_W-1:0]         res_right
);

    localparam int MAG_W  = dclp_pkg::MAG_W;
    localparam int PROD_W = MAG_W + 4;
    localparam int VAL_W  = MAG_W + 1;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef enum logic [6:0] {
        PH_FIRST_LEAD  = 7'b0000001,
        PH_FIRST_SIGN  = 7'b0000010,
        PH_FIRST_DIG   = 7'b0000100,
        PH_SECOND_LEAD = 7'b0001000,
        PH_SECOND_SIGN = 7'b0010000,
        PH_SECOND_DIG  = 7'b0100000,
        PH_SECOND_TAIL = 7'b1000000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [MAG_W-1:0]    mag1_reg, mag1_next, mag2_reg, mag2_next;
    logic [1:0]          sign_reg, sign_next;
    logic                bad_reg, bad_next;
    logic [dclp_pkg::SPEED_W-1:0] upper_reg, lower_reg;
    logic [dclp_pkg::SPEED_W-1:0] left_reg, left_next, right_reg, right_next;
    logic                out_valid_reg;
    dclp_pkg::status_t   status_reg, status_next;
    logic                is_digit, is_sign, is_ws, is_space;

    // decimal digit accumulate with saturation
    function automatic logic [MAG_W-1:0] mag_push(input logic [MAG_W-1:0] m,
                                                  input logic [dclp_pkg::DIGIT_W-1:0] d);
        logic [PROD_W-1:0] n;
        n = (PROD_W'(m) << 3) + (PROD_W'(m) << 1) + PROD_W'(d);
        mag_push = (n > PROD_W'(MAG_MAX)) ? MAG_MAX : n[MAG_W-1:0];
    endfunction

    // sign, then limit to upper, then raise to lower
    function automatic logic [dclp_pkg::SPEED_W-1:0] finish_value(
        input logic [MAG_W-1:0] mag, input logic neg,
        input logic [dclp_pkg::SPEED_W-1:0] hi, input logic [dclp_pkg::SPEED_W-1:0] lo);
        logic signed [VAL_W-1:0] v, hi_x, lo_x;
        v    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        hi_x = VAL_W'($signed(hi));
        lo_x = VAL_W'($signed(lo));
        if (v > hi_x) v = hi_x;
        if (v < lo_x) v = lo_x;
        finish_value = v[dclp_pkg::SPEED_W-1:0];
    endfunction

    assign is_digit = (item.cls == dclp_pkg::CC_DIGIT);
    assign is_sign  = (item.cls == dclp_pkg::CC_PLUS) || (item.cls == dclp_pkg::CC_MINUS);
    assign is_space = (item.cls == dclp_pkg::CC_SPACE);
    assign is_ws    = is_space || (item.cls == dclp_pkg::CC_WS_OTHER);

    // take an item whenever the result slot is free or being emptied
    assign item_pop = item_valid && (!out_valid_reg || res_ready);

    // parse step and line end evaluation
    always_comb begin
        phase_next  = phase_reg;
        mag1_next   = mag1_reg;
        mag2_next   = mag2_reg;
        sign_next   = sign_reg;
        bad_next    = bad_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        status_next = dclp_pkg::ST_INCOMPLETE;
        unique case (item.kind)
            dclp_pkg::KIND_SKIP: begin
                status_next = dclp_pkg::ST_INCOMPLETE;
            end
            dclp_pkg::KIND_CHAR: begin
                if (!bad_reg) begin
                    unique case (phase_reg) inside
                        PH_FIRST_LEAD: begin
                            if (is_ws) begin
                                phase_next = phase_reg;
                            end else if (is_sign) begin
                                if (item.cls == dclp_pkg::CC_MINUS) sign_next[0] = 1'b1;
                                phase_next = PH_FIRST_SIGN;
                            end else if (is_digit) begin
                                mag1_next  = mag_push(mag1_reg, item.digit);
                                phase_next = PH_FIRST_DIG;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        PH_FIRST_SIGN, PH_FIRST_DIG: begin
                            if (is_digit) begin
                                mag1_next  = mag_push(mag1_reg, item.digit);
                                phase_next = PH_FIRST_DIG;
                            end else if (item.cls == dclp_pkg::CC_COMMA &&
                                         phase_reg == PH_FIRST_DIG) begin
                                phase_next = PH_SECOND_LEAD;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        PH_SECOND_LEAD: begin
                            if (is_ws) begin
                                phase_next = phase_reg;
                            end else if (is_sign) begin
                                if (item.cls == dclp_pkg::CC_MINUS) sign_next[1] = 1'b1;
                                phase_next = PH_SECOND_SIGN;
                            end else if (is_digit) begin
                                mag2_next  = mag_push(mag2_reg, item.digit);
                                phase_next = PH_SECOND_DIG;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        PH_SECOND_SIGN, PH_SECOND_DIG: begin
                            if (is_digit) begin
                                mag2_next  = mag_push(mag2_reg, item.digit);
                                phase_next = PH_SECOND_DIG;
                            end else if (is_space && phase_reg == PH_SECOND_DIG) begin
                                phase_next = PH_SECOND_TAIL;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        PH_SECOND_TAIL: begin
                            if (!is_space) bad_next = 1'b1;
                        end
                        default: begin
                            bad_next = 1'b1;
                        end
                    endcase
                end
            end
            dclp_pkg::KIND_END_STOP, dclp_pkg::KIND_END_EVAL,
            dclp_pkg::KIND_OVERFLOW: begin
                if (item.kind == dclp_pkg::KIND_END_STOP) begin
                    status_next = dclp_pkg::ST_STOP;
                end else if (item.kind == dclp_pkg::KIND_END_EVAL && !bad_reg &&
                             (phase_reg == PH_SECOND_DIG || phase_reg == PH_SECOND_TAIL)) begin
                    left_next   = finish_value(mag1_reg, sign_reg[0], upper_reg, lower_reg);
                    right_next  = finish_value(mag2_reg, sign_reg[1], upper_reg, lower_reg);
                    status_next = dclp_pkg::ST_DRIVE;
                end else begin
                    status_next = dclp_pkg::ST_ERROR;
                end
                phase_next = PH_FIRST_LEAD;
                mag1_next  = '0;
                mag2_next  = '0;
                sign_next  = '0;
                bad_next   = 1'b0;
            end
            default: begin
                status_next = dclp_pkg::ST_ERROR;
            end
        endcase
    end

    // parse state and held speeds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST_LEAD;
            mag1_reg  <= '0;
            mag2_reg  <= '0;
            sign_reg  <= '0;
            bad_reg   <= 1'b0;
            left_reg  <= '0;
            right_reg <= '0;
        end else if (item_pop) begin
            phase_reg <= phase_next;
            mag1_reg  <= mag1_next;
            mag2_reg  <= mag2_next;
            sign_reg  <= sign_next;
            bad_reg   <= bad_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            status_reg    <= dclp_pkg::ST_INCOMPLETE;
        end else if (item_pop) begin
            out_valid_reg <= 1'b1;
            status_reg    <= status_next;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // speed limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= dclp_pkg::SPEED_UPPER_RESET;
            lower_reg <= dclp_pkg::SPEED_LOWER_RESET;
        end else if (cfg_write) begin
            if (cfg_index == dclp_pkg::REG_SPEED_UPPER) upper_reg <= cfg_data;
            if (cfg_index == dclp_pkg::REG_SPEED_LOWER) lower_reg <= cfg_data;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_status = status_reg;
    assign res_left   = left_reg;
    assign res_right  = right_reg;

endmodule

/* rtl/drive_command_line_parser.sv */
// ----------------------------------------------------------------------------
// drive_command_line_parser: serial drive command line parser
// Parses LF or CR terminated text lines, one byte per transfer, into stop and
// drive results with clamped left and right speeds.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result transfer, in order. The block
// takes one byte per clock cycle sustained while the item queue has room; a
// result passes from the front classifier through the item queue and the
// one-step parser in the back end, which loads the result register and sets
// the rate. The queue of QUEUE_DEPTH items lets intake continue while a
// result waits to be taken. The user must write speed limits through the cfg
// port only while no line is in flight; the block does not enforce this.
module drive_command_line_parser #(
    parameter int LINE_CAPACITY = dclp_pkg::LINE_CAPACITY_DEFAULT,
    parameter int QUEUE_DEPTH   = dclp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // byte input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] rx_byte
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [39:0]                          m_tdata,   // [1:0] status,
                                                            // [17:2] left_speed,
                                                            // [33:18] right_speed
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dclp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dclp_pkg::SPEED_W-1:0]         cfg_data
);

    logic                              q_in_ready;
    logic                              front_valid;
    dclp_pkg::q_item_t                 front_item;
    logic                              q_valid, q_pop;
    dclp_pkg::q_item_t                 q_item;
    logic [dclp_pkg::STATUS_W-1:0]     res_status;
    logic [dclp_pkg::SPEED_W-1:0]      res_left, res_right;

    assign s_tready  = q_in_ready;
    assign cfg_ready = 1'b1;

    // byte intake and classification
    dclp_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && q_in_ready),
        .byte_data  (s_tdata),
        .item_valid (front_valid),
        .item       (front_item)
    );

    // item queue
    dclp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_item (front_item),
        .in_ready  (q_in_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    // parser and result register
    dclp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_left   (res_left),
        .res_right  (res_right)
    );

    // pack result fields, lowest field first
    assign m_tdata = {6'd0, res_right, res_left, res_status};

endmodule

/* bench/drive_command_line_parser_checker.sv */
// ----------------------------------------------------------------------------
// drive_command_line_parser_checker: result predictor and comparator
// Watches the byte, result and configuration channels, runs its own line
// parser on every accepted byte and compares each result transfer with the
// oldest predicted reply.
// ----------------------------------------------------------------------------
module drive_command_line_parser_checker
    import dclp_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] rx_byte
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [39:0]            m_tdata,    // [1:0] status, [17:2] left_speed,
                                               // [33:18] right_speed
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SPEED_W-1:0]     cfg_data,
    output int unsigned            replies_due,
    output int unsigned            fail_count
);

    // characters the parser cares about
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // stop word tracking
    localparam logic [31:0] WORD_UPPER = "STOP";
    localparam logic [31:0] WORD_LOWER = "stop";
    localparam logic [3:0]  STOP_NONE        = 4'd0;
    localparam logic [3:0]  STOP_UPPER_FIRST = 4'd1;
    localparam logic [3:0]  STOP_UPPER_DONE  = 4'd4;
    localparam logic [3:0]  STOP_LOWER_FIRST = 4'd5;
    localparam logic [3:0]  STOP_LOWER_DONE  = 4'd8;
    localparam logic [3:0]  STOP_MISS        = 4'd15;

    localparam logic [31:0] MAG_LIMIT = 32'd131071;

    typedef enum logic [2:0] {
        PH_FIRST_LEAD,
        PH_FIRST_SIGN,
        PH_FIRST_DIG,
        PH_SECOND_LEAD,
        PH_SECOND_SIGN,
        PH_SECOND_DIG,
        PH_SECOND_TAIL
    } parse_phase_t;

    typedef struct packed {
        status_t              status;
        logic [SPEED_W-1:0]   left;
        logic [SPEED_W-1:0]   right;
    } drive_reply_t;

    // parser copy
    logic signed [SPEED_W-1:0] upper_lim;
    logic signed [SPEED_W-1:0] lower_lim;
    logic signed [SPEED_W-1:0] held_left;
    logic signed [SPEED_W-1:0] held_right;
    int unsigned               line_len;
    parse_phase_t              phase;
    logic [3:0]                stop_state;
    logic [31:0]               first_mag;
    logic [31:0]               second_mag;
    logic                      neg_first;
    logic                      neg_second;
    logic                      line_bad;
    logic                      truncated;

    drive_reply_t              predicted_replies[$];
    int unsigned               fails;

    function automatic void clear_line();
        line_len   = 0;
        phase      = PH_FIRST_LEAD;
        stop_state = STOP_NONE;
        first_mag  = '0;
        second_mag = '0;
        neg_first  = 1'b0;
        neg_second = 1'b0;
        line_bad   = 1'b0;
        truncated  = 1'b0;
    endfunction

    function automatic void reset_parser();
        upper_lim  = SPEED_UPPER_RESET;
        lower_lim  = SPEED_LOWER_RESET;
        held_left  = '0;
        held_right = '0;
        clear_line();
    endfunction

    // decimal accumulate with saturation
    function automatic logic [31:0] push_digit(input logic [31:0] mag, input logic [7:0] c);
        logic [31:0] n;
        n = mag * 10 + 32'(c - CH_ZERO);
        return (n > MAG_LIMIT) ? MAG_LIMIT : n;
    endfunction

    // upper limit first, then lower limit, so lower wins when crossed
    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [31:0] mag, input logic neg);
        int v;
        v = neg ? -int'(mag) : int'(mag);
        if (v > int'(upper_lim)) v = int'(upper_lim);
        if (v < int'(lower_lim)) v = int'(lower_lim);
        return 16'(v);
    endfunction

    function automatic void track_stop(input logic [7:0] c);
        int k;
        if (stop_state == STOP_NONE) begin
            if (c == WORD_UPPER[31:24]) stop_state = STOP_UPPER_FIRST;
            else if (c == WORD_LOWER[31:24]) stop_state = STOP_LOWER_FIRST;
            else stop_state = STOP_MISS;
        end else if (stop_state >= STOP_UPPER_FIRST && stop_state < STOP_UPPER_DONE) begin
            k = int'(stop_state - STOP_UPPER_FIRST) + 1;
            stop_state = (c == WORD_UPPER[31 - 8*k -: 8]) ? 4'(stop_state + 1) : STOP_MISS;
        end else if (stop_state >= STOP_LOWER_FIRST && stop_state < STOP_LOWER_DONE) begin
            k = int'(stop_state - STOP_LOWER_FIRST) + 1;
            stop_state = (c == WORD_LOWER[31 - 8*k -: 8]) ? 4'(stop_state + 1) : STOP_MISS;
        end else begin
            stop_state = STOP_MISS;
        end
    endfunction

    // one character of the integer,integer syntax
    function automatic void parse_char(input logic [7:0] c);
        logic blank;
        logic ws;
        logic dig;
        logic sgn;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        ws    = blank || (c == CH_VT) || (c == CH_FF);
        dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        sgn   = (c == CH_PLUS) || (c == CH_MINUS);
        track_stop(c);
        if (!line_bad) begin
            case (phase)
                PH_FIRST_LEAD: begin
                    if (sgn) begin
                        if (c == CH_MINUS) neg_first = 1'b1;
                        phase = PH_FIRST_SIGN;
                    end else if (dig) begin
                        first_mag = push_digit(first_mag, c);
                        phase     = PH_FIRST_DIG;
                    end else if (!ws) begin
                        line_bad = 1'b1;
                    end
                end
                PH_FIRST_SIGN, PH_FIRST_DIG: begin
                    if (dig) begin
                        first_mag = push_digit(first_mag, c);
                        phase     = PH_FIRST_DIG;
                    end else if (c == CH_COMMA && phase == PH_FIRST_DIG) begin
                        phase = PH_SECOND_LEAD;
                    end else begin
                        line_bad = 1'b1;
                    end
                end
                PH_SECOND_LEAD: begin
                    if (sgn) begin
                        if (c == CH_MINUS) neg_second = 1'b1;
                        phase = PH_SECOND_SIGN;
                    end else if (dig) begin
                        second_mag = push_digit(second_mag, c);
                        phase      = PH_SECOND_DIG;
                    end else if (!ws) begin
                        line_bad = 1'b1;
                    end
                end
                PH_SECOND_SIGN, PH_SECOND_DIG: begin
                    if (dig) begin
                        second_mag = push_digit(second_mag, c);
                        phase      = PH_SECOND_DIG;
                    end else if (phase == PH_SECOND_DIG && blank) begin
                        phase = PH_SECOND_TAIL;
                    end else begin
                        line_bad = 1'b1;
                    end
                end
                PH_SECOND_TAIL: begin
                    if (!blank) line_bad = 1'b1;
                end
                default: begin
                    line_bad = 1'b1;
                end
            endcase
        end
    endfunction

    // status for one received byte, updates the held speeds
    function automatic status_t parse_byte(input logic [7:0] c);
        status_t st;
        st = ST_INCOMPLETE;
        if (c == CH_LF || c == CH_CR) begin
            if (line_len != 0) begin
                if (stop_state == STOP_UPPER_DONE || stop_state == STOP_LOWER_DONE) begin
                    st = ST_STOP;
                end else if (!line_bad && (phase == PH_SECOND_DIG || phase == PH_SECOND_TAIL)) begin
                    held_left  = clamp_speed(first_mag, neg_first);
                    held_right = clamp_speed(second_mag, neg_second);
                    st = ST_DRIVE;
                end else begin
                    st = ST_ERROR;
                end
                clear_line();
            end
        end else if (line_len < LINE_CAPACITY - 1) begin
            line_len++;
            if (c == CH_NUL) truncated = 1'b1;
            else if (!truncated) parse_char(c);
        end else begin
            // line at capacity is dropped
            clear_line();
            st = ST_ERROR;
        end
        return st;
    endfunction

    // watch all channels, results are checked before new bytes are predicted
    always @(posedge aclk) begin
        drive_reply_t want;
        status_t      st;
        logic [1:0]   got_status;
        logic [15:0]  got_left;
        logic [15:0]  got_right;
        if (!aresetn) begin
            reset_parser();
            predicted_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPEED_UPPER: upper_lim = cfg_data;
                    REG_SPEED_LOWER: lower_lim = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[1:0];
                got_left   = m_tdata[17:2];
                got_right  = m_tdata[33:18];
                if (predicted_replies.size() == 0) begin
                    $error("result transfer with no byte pending: status %0d left %0d right %0d",
                           got_status, $signed(got_left), $signed(got_right));
                    fails++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got_status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        fails++;
                    end
                    if (got_left != want.left) begin
                        $error("left_speed: expected %0d, actual %0d",
                               $signed(want.left), $signed(got_left));
                        fails++;
                    end
                    if (got_right != want.right) begin
                        $error("right_speed: expected %0d, actual %0d",
                               $signed(want.right), $signed(got_right));
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                st = parse_byte(s_tdata);
                want.status = st;
                want.left   = held_left;
                want.right  = held_right;
                predicted_replies.push_back(want);
            end
        end
        replies_due <= predicted_replies.size();
        fail_count  <= fails;
    end

endmodule

/* bench/drive_command_line_parser_test.sv */
// ----------------------------------------------------------------------------
// drive_command_line_parser_test: top level bench of the line parser
// Sends directed and random text lines (drive commands, stop words, empty,
// noisy, truncated and over-long lines) under several speed limit settings,
// with random gaps on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module drive_command_line_parser_test;
    import dclp_pkg::*;

    localparam int LINE_CAP       = LINE_CAPACITY_DEFAULT;
    localparam int RESET_CYCLES   = 6;
    localparam int TOTAL_BYTES    = 1750;
    localparam int PHASES         = 6;
    localparam int LONG_STALL     = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;   // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;          // [1:0] status, [17:2] left_speed,
                                              // [33:18] right_speed
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SPEED_W-1:0]     cfg_data  = '0;

    int unsigned            replies_due;
    int unsigned            fail_count;

    // stimulus bookkeeping
    logic [7:0]             line_buf[$];
    int unsigned            bytes_sent;
    int unsigned            calm_bytes;
    int unsigned            stall_requests;

    // receiver side state
    int unsigned            stalls_served;
    int unsigned            stall_left;
    int unsigned            gap_left;
    int unsigned            calm_left;
    int unsigned            idle_cycles;

    always #5 aclk = ~aclk;

    drive_command_line_parser #(
        .LINE_CAPACITY (LINE_CAP)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drive_command_line_parser_checker #(
        .LINE_CAPACITY (LINE_CAP)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .replies_due (replies_due),
        .fail_count  (fail_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic void push_word(input string s);
        int k;
        for (k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endfunction

    // optional whitespace and sign, then digits, some long enough to saturate
    function automatic void put_number(input bit second);
        int unsigned r;
        int unsigned n_digits;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(pick_ws());
        r = $urandom_range(0, 9);
        if (r == 0) line_buf.push_back(CH_MINUS);
        else if (r < 3) line_buf.push_back(CH_PLUS);
        r = $urandom_range(0, 19);
        n_digits = (r == 0) ? 0 : (r < 16) ? $urandom_range(1, 5) : $urandom_range(6, 9);
        repeat (n_digits) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if (second && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
    endfunction

    // one random line, always closed by a terminator
    function automatic void build_line();
        int unsigned kind;
        int unsigned n;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 67) begin
            if (kind < 55) begin
                put_number(1'b0);
                line_buf.push_back(CH_COMMA);
                put_number(1'b1);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_word("STOP");
                    4, 5, 6:    push_word("stop");
                    7:          push_word("StOP");
                    8:          push_word("sto");
                    default:    push_word("STOP ");
                endcase
            end
            // corrupt a byte or truncate the text now and then
            if ($urandom_range(0, 9) == 0)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = any_text_byte();
            if ($urandom_range(0, 11) == 0)
                line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
        end else if (kind < 75) begin
            // empty line
        end else if (kind < 78) begin
            // over-long line around and past the capacity
            n = $urandom_range(LINE_CAP - 3, LINE_CAP + 30);
            repeat (n) begin
                if ($urandom_range(0, 9) < 6) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                else line_buf.push_back(any_text_byte());
            end
        end else begin
            // raw noise, terminators included
            repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 5))
            0, 1, 2: line_buf.push_back(CH_LF);
            3, 4:    line_buf.push_back(CH_CR);
            default: begin
                line_buf.push_back(CH_CR);
                line_buf.push_back(CH_LF);
            end
        endcase
    endfunction

    // offer one byte and wait for its transfer
    task automatic send_byte(input logic [7:0] b);
        int unsigned idle;
        idle = 0;
        if (calm_bytes != 0) calm_bytes--;
        else if ($urandom_range(0, 99) < 30) idle = pick_gap();
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_line();
        int k;
        for (k = 0; k < line_buf.size(); k++) send_byte(line_buf[k]);
    endtask

    // sender pauses until every predicted reply has been taken
    task automatic wait_replies_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_due != 0) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [15:0] upper, input logic [15:0] lower);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SPEED_UPPER;
        cfg_data  <= upper;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_SPEED_LOWER;
        cfg_data  <= lower;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side ready: random gaps, calm stretches and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_requests != stalls_served) begin
            stalls_served <= stall_requests;
            stall_left    <= LONG_STALL;
            m_tready      <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (calm_left != 0) calm_left <= calm_left - 1;
            else if ($urandom_range(0, 99) < 25) gap_left <= pick_gap();
            else if ($urandom_range(0, 99) < 3) calm_left <= $urandom_range(20, 100);
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("drive_command_line_parser_test NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned      p;
        int unsigned      phase_end;
        logic [15:0]      up;
        logic [15:0]      lo;
        bit               stall_done;
        stall_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines under the reset limits
        send_text("\n");
        send_text("stop\r");
        send_text("9,9");
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_text("\n");
        send_text("-999999, 5\n");
        send_byte(8'hFF);
        send_text("\n");

        // random lines under a series of limit settings
        for (p = 0; p < PHASES; p++) begin
            wait_replies_done();
            case (p)
                0: begin up = 16'h7FFF; lo = 16'h8000; end   // widest range
                1: begin up = 16'd0;    lo = 16'd0;    end
                2: begin up = -16'sd50; lo = 16'sd50;  end   // crossed
                3: begin up = 16'h8000; lo = 16'h7FFF; end   // crossed extremes
                4: begin up = 16'sd100; lo = -16'sd100; end
                default: begin
                    up = 16'($urandom_range(0, 65535));
                    lo = 16'($urandom_range(0, 65535));
                end
            endcase
            write_limits(up, lo);
            phase_end = (p + 1) * TOTAL_BYTES / PHASES;
            while (bytes_sent < phase_end) begin
                if (p == 1 && !stall_done) begin
                    // receiver holds off while bytes keep coming
                    stall_requests <= stall_requests + 1;
                    calm_bytes = 120;
                    stall_done = 1'b1;
                end else if ($urandom_range(0, 19) == 0) begin
                    calm_bytes = $urandom_range(10, 40);
                end
                build_line();
                send_line();
            end
        end

        wait_replies_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("drive_command_line_parser_test OK");
        end else begin
            $display("drive_command_line_parser_test NOT OK");
        end
        $finish;
    end

endmodule
